>>> src/dst_pkg.sv
// Shared types, codes and constants of the display slide transition engine.
// No dependencies; every other file of the block imports this package.
package dst_pkg;

   localparam int MAX_DIM    = 256;
   localparam int CFG_DIM_W  = 9;
   localparam int DIM_W      = $clog2(MAX_DIM + 1);
   localparam int OFS_W      = $clog2(MAX_DIM) + 2;
   localparam int CRD_W      = OFS_W + 2;
   localparam int PIX_W      = 8;
   localparam int ALPHA_W    = 8;
   localparam int SPEED_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [ALPHA_W-1:0] FADE_STEP = ALPHA_W'(20);
   localparam logic [ALPHA_W-1:0] FADE_MAX  = ALPHA_W'(255);

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_STEP   = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_FINISH = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_FADE     = 2'd0,
      MODE_SLIDE    = 2'd1,
      MODE_SLIDE_BG = 2'd2,
      MODE_SHIFT    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      SRC_LEAVE = 2'd0,
      SRC_FG    = 2'd1,
      SRC_BG    = 2'd2,
      SRC_BLEND = 2'd3
   } src_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = CSR_IDX_W'(4);

   localparam mode_type                RST_MODE   = MODE_SLIDE;
   localparam dir_type                 RST_DIR    = DIR_UP;
   localparam logic [SPEED_W-1:0]      RST_SPEED  = SPEED_W'(1);
   localparam logic [CFG_DIM_W-1:0]    RST_WIDTH  = CFG_DIM_W'(64);
   localparam logic [CFG_DIM_W-1:0]    RST_HEIGHT = CFG_DIM_W'(32);

   typedef struct packed {
      mode_type              mode;
      dir_type               direction;
      logic [SPEED_W-1:0]    speed;
      logic [CFG_DIM_W-1:0]  frame_width;
      logic [CFG_DIM_W-1:0]  frame_height;
   } cfg_type;

   typedef struct packed {
      logic [ALPHA_W-1:0]      frame_alpha;
      logic signed [OFS_W-1:0] x_offset;
      logic signed [OFS_W-1:0] y_offset;
   } view_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0)
         r = DIM_W'(1);
      else if (v > MAX_DIM)
         r = DIM_W'(MAX_DIM);
      else
         r = DIM_W'(v);
      return r;
   endfunction

endpackage

>>> src/display_slide_transition_top.sv
// Display slide transition engine: fade, slide, slide over background and shift,
// in four directions. Each accepted beat passes the input register, then the result
// register, before its result beat leaves. Every action, a pixel query included,
// completes combinationally between those two registers, so a new beat is taken
// each cycle while rsp_stall stays low; a stalled result holds the result
// register and, once the input register is also full, raises req_stall in the
// same cycle. Write the csr_ registers only while no beat is in flight. Depends
// on dst_pkg, dst_csr, dst_state and dst_query.
module display_slide_transition_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_action,
   input  logic [dst_pkg::PIX_W-1:0]        req_pixel_x,
   input  logic [dst_pkg::PIX_W-1:0]        req_pixel_y,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_running,
   output logic                             rsp_frame_drawn,
   output logic [1:0]                       rsp_source,
   output logic [dst_pkg::PIX_W-1:0]        rsp_src_x,
   output logic [dst_pkg::PIX_W-1:0]        rsp_src_y,
   output logic [dst_pkg::ALPHA_W-1:0]      rsp_alpha,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dst_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dst_pkg::*;

   logic               in_vld_ff, in_vld_in;
   action_type         in_act_ff, in_act_in;
   logic [PIX_W-1:0]   in_x_ff, in_x_in;
   logic [PIX_W-1:0]   in_y_ff, in_y_in;

   logic               out_vld_ff, out_vld_in;
   logic               out_run_ff, out_run_in;
   logic               out_drawn_ff, out_drawn_in;
   src_type            out_src_ff, out_src_in;
   logic [PIX_W-1:0]   out_x_ff, out_x_in;
   logic [PIX_W-1:0]   out_y_ff, out_y_in;
   logic [ALPHA_W-1:0] out_alpha_ff, out_alpha_in;

   logic               out_open, advance, accept;
   cfg_type            cfg;
   view_type           view;
   logic               running, drawn;
   src_type            q_src;
   logic [PIX_W-1:0]   q_x, q_y;
   logic [ALPHA_W-1:0] q_alpha;

   assign csr_ready = 1'b1;
   assign out_open  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_open;
   assign req_stall = in_vld_ff && !out_open;
   assign accept    = req_valid && !req_stall;

   dst_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   dst_state u_state (
      .clock   (clock),
      .reset   (reset),
      .go      (advance),
      .action  (in_act_ff),
      .cfg     (cfg),
      .view    (view),
      .running (running),
      .drawn   (drawn)
   );

   dst_query u_query (
      .is_query (in_act_ff == ACT_QUERY),
      .pixel_x  (in_x_ff),
      .pixel_y  (in_y_ff),
      .cfg      (cfg),
      .view     (view),
      .source   (q_src),
      .src_x    (q_x),
      .src_y    (q_y),
      .alpha    (q_alpha)
   );

   always_comb begin
      in_vld_in = accept || (in_vld_ff && !out_open);
      in_act_in = accept ? action_type'(req_action) : in_act_ff;
      in_x_in   = accept ? req_pixel_x : in_x_ff;
      in_y_in   = accept ? req_pixel_y : in_y_ff;

      out_vld_in   = advance || (out_vld_ff && rsp_stall);
      out_run_in   = advance ? running : out_run_ff;
      out_drawn_in = advance ? drawn   : out_drawn_ff;
      out_src_in   = advance ? q_src   : out_src_ff;
      out_x_in     = advance ? q_x     : out_x_ff;
      out_y_in     = advance ? q_y     : out_y_ff;
      out_alpha_in = advance ? q_alpha : out_alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_act_ff    <= in_act_in;
      in_x_ff      <= in_x_in;
      in_y_ff      <= in_y_in;
      out_run_ff   <= out_run_in;
      out_drawn_ff <= out_drawn_in;
      out_src_ff   <= out_src_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_alpha_ff <= out_alpha_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_running     = out_run_ff;
   assign rsp_frame_drawn = out_drawn_ff;
   assign rsp_source      = out_src_ff;
   assign rsp_src_x       = out_x_ff;
   assign rsp_src_y       = out_y_ff;
   assign rsp_alpha       = out_alpha_ff;

endmodule

>>> src/dst_csr.sv
// Configuration registers of the transition engine: mode, direction, speed, frame size.
// Depends on dst_pkg.
module dst_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [dst_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [dst_pkg::CSR_DATA_W-1:0] wr_data,
   output dst_pkg::cfg_type               cfg
);
   import dst_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_MODE:      cfg_in.mode         = mode_type'(wr_data[1:0]);
            CSR_DIRECTION: cfg_in.direction    = dir_type'(wr_data[1:0]);
            CSR_SPEED:     cfg_in.speed        = wr_data[SPEED_W-1:0];
            CSR_WIDTH:     cfg_in.frame_width  = wr_data[CFG_DIM_W-1:0];
            CSR_HEIGHT:    cfg_in.frame_height = wr_data[CFG_DIM_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= RST_MODE;
         cfg_ff.direction    <= RST_DIR;
         cfg_ff.speed        <= RST_SPEED;
         cfg_ff.frame_width  <= RST_WIDTH;
         cfg_ff.frame_height <= RST_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/dst_state.sv
// Transition state: offsets, fade level, last frame alpha and the active flag.
// Handles start, frame step and finish beats. Depends on dst_pkg.
module dst_state (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  dst_pkg::action_type action,
   input  dst_pkg::cfg_type    cfg,
   output dst_pkg::view_type   view,
   output logic                running,
   output logic                drawn
);
   import dst_pkg::*;

   logic [ALPHA_W-1:0]      fade_ff, fade_in;
   logic [ALPHA_W-1:0]      alpha_ff, alpha_in;
   logic signed [OFS_W-1:0] xo_ff, xo_in;
   logic signed [OFS_W-1:0] yo_ff, yo_in;
   logic                    active_ff, active_in;

   logic signed [OFS_W:0]   sp, xe, ye, t;
   logic signed [OFS_W-1:0] xmv, ymv;
   logic [ALPHA_W:0]        fsum;
   logic [ALPHA_W-1:0]      fade_sat;
   logic [DIM_W-1:0]        dim_w, dim_h;

   always_comb begin
      sp  = (OFS_W+1)'(cfg.speed);
      xe  = (OFS_W+1)'(xo_ff);
      ye  = (OFS_W+1)'(yo_ff);
      xmv = xo_ff;
      ymv = yo_ff;
      t   = '0;
      case (cfg.direction)
         DIR_UP: begin
            t = ye + sp;
            ymv = (t > 0) ? '0 : OFS_W'(t);
         end
         DIR_DOWN: begin
            t = ye - sp;
            ymv = (t < 0) ? '0 : OFS_W'(t);
         end
         DIR_LEFT: begin
            t = xe + sp;
            xmv = (t > 0) ? '0 : OFS_W'(t);
         end
         default: begin
            t = xe - sp;
            xmv = (t < 0) ? '0 : OFS_W'(t);
         end
      endcase
   end

   always_comb begin
      fsum     = {1'b0, fade_ff} + {1'b0, FADE_STEP};
      fade_sat = (fsum > {1'b0, FADE_MAX}) ? FADE_MAX : fsum[ALPHA_W-1:0];
      dim_w    = eff_dim(cfg.frame_width);
      dim_h    = eff_dim(cfg.frame_height);
   end

   always_comb begin
      fade_in   = fade_ff;
      alpha_in  = alpha_ff;
      xo_in     = xo_ff;
      yo_in     = yo_ff;
      active_in = active_ff;
      drawn     = 1'b0;
      case (action)
         ACT_START: begin
            fade_in   = '0;
            xo_in     = '0;
            yo_in     = '0;
            active_in = 1'b1;
            case (cfg.direction)
               DIR_UP:    yo_in = OFS_W'(0) - OFS_W'(dim_h);
               DIR_DOWN:  yo_in = OFS_W'(dim_h);
               DIR_LEFT:  xo_in = OFS_W'(0) - OFS_W'(dim_w);
               default:   xo_in = OFS_W'(dim_w);
            endcase
         end
         ACT_STEP: begin
            if (active_ff) begin
               drawn = 1'b1;
               if (cfg.mode == MODE_FADE) begin
                  alpha_in = fade_ff;
                  if (fade_ff == FADE_MAX)
                     active_in = 1'b0;
                  else
                     fade_in = fade_sat;
               end else begin
                  xo_in = xmv;
                  yo_in = ymv;
                  if (xmv == '0 && ymv == '0)
                     active_in = 1'b0;
               end
            end
         end
         ACT_FINISH: begin
            if (active_ff) begin
               drawn     = 1'b1;
               active_in = 1'b0;
               if (cfg.mode == MODE_FADE) begin
                  fade_in  = FADE_MAX;
                  alpha_in = FADE_MAX;
               end else begin
                  xo_in = '0;
                  yo_in = '0;
               end
            end
         end
         default: begin
            active_in = active_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ff   <= '0;
         alpha_ff  <= '0;
         xo_ff     <= '0;
         yo_ff     <= '0;
         active_ff <= 1'b0;
      end else if (go) begin
         fade_ff   <= fade_in;
         alpha_ff  <= alpha_in;
         xo_ff     <= xo_in;
         yo_ff     <= yo_in;
         active_ff <= active_in;
      end
   end

   assign running          = active_in;
   assign view.frame_alpha = alpha_ff;
   assign view.x_offset    = xo_ff;
   assign view.y_offset    = yo_ff;

endmodule

>>> src/dst_query.sv
// Pixel query mapper: picks the source buffer and coordinates, or the fade alpha,
// for one destination pixel of the current frame. Depends on dst_pkg.
module dst_query (
   input  logic                      is_query,
   input  logic [dst_pkg::PIX_W-1:0] pixel_x,
   input  logic [dst_pkg::PIX_W-1:0] pixel_y,
   input  dst_pkg::cfg_type          cfg,
   input  dst_pkg::view_type         view,
   output dst_pkg::src_type          source,
   output logic [dst_pkg::PIX_W-1:0] src_x,
   output logic [dst_pkg::PIX_W-1:0] src_y,
   output logic [dst_pkg::ALPHA_W-1:0] alpha
);
   import dst_pkg::*;

   logic signed [CRD_W-1:0] w, h, xs, ys, xo, yo, ix, iy, sx, sy;
   logic                    in_view;
   src_type                 src;

   always_comb begin
      w  = CRD_W'(eff_dim(cfg.frame_width));
      h  = CRD_W'(eff_dim(cfg.frame_height));
      xs = CRD_W'(pixel_x);
      ys = CRD_W'(pixel_y);
      xo = CRD_W'(view.x_offset);
      yo = CRD_W'(view.y_offset);
      ix = xs + xo;
      iy = ys + yo;
      in_view = (ix >= 0) && (ix < w) && (iy >= 0) && (iy < h);

      sx = xs;
      sy = ys;
      if (in_view) begin
         if (cfg.mode == MODE_SLIDE_BG) begin
            src = SRC_BG;
         end else begin
            src = SRC_FG;
            sx  = ix;
            sy  = iy;
         end
      end else begin
         src = (cfg.mode == MODE_SLIDE_BG) ? SRC_FG : SRC_BG;
         case (cfg.direction)
            DIR_UP:   sy = ys + h + yo;
            DIR_DOWN: sy = ys - h + yo;
            DIR_LEFT: sx = xs + w + xo;
            default:  sx = xs - w + xo;
         endcase
      end

      source = SRC_LEAVE;
      src_x  = '0;
      src_y  = '0;
      alpha  = '0;
      if (is_query && xs < w && ys < h) begin
         if (cfg.mode == MODE_FADE) begin
            source = SRC_BLEND;
            src_x  = pixel_x;
            src_y  = pixel_y;
            alpha  = view.frame_alpha;
         end else if (!(!in_view && cfg.mode == MODE_SLIDE) &&
                      sx >= 0 && sx < w && sy >= 0 && sy < h) begin
            source = src;
            src_x  = sx[PIX_W-1:0];
            src_y  = sy[PIX_W-1:0];
         end
      end
   end

endmodule

>>> src/dst_check.sv
// Port-level checks of the transition engine's result channel, bound to the top.
// Depends on dst_pkg and display_slide_transition_top.
module dst_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_frame_drawn,
   input logic [1:0]                  rsp_source,
   input logic [dst_pkg::PIX_W-1:0]   rsp_src_x,
   input logic [dst_pkg::PIX_W-1:0]   rsp_src_y,
   input logic [dst_pkg::ALPHA_W-1:0] rsp_alpha
);
   import dst_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_source) &&
         $stable(rsp_src_x) && $stable(rsp_src_y) && $stable(rsp_alpha))
      else $error("stalled result beat changed");

   a_leave_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_source == SRC_LEAVE |->
         rsp_src_x == '0 && rsp_src_y == '0 && rsp_alpha == '0)
      else $error("leave-pixel beat carries coordinates or alpha");

   a_alpha_blend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alpha != '0 |-> rsp_source == SRC_BLEND)
      else $error("alpha outside a blend beat");

   a_drawn_no_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_drawn |-> rsp_source == SRC_LEAVE)
      else $error("frame beat also answers a pixel");

endmodule

bind display_slide_transition_top dst_check u_check (.*);

>>> tb/dst_result_checker.sv
`timescale 1ns / 100ps
// Response checker for the display slide transition engine: follows register writes and
// request beats, predicts each response beat and compares it field by field.
// Depends on dst_pkg for the port widths, codes and reset values.
module dst_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [dst_pkg::PIX_W-1:0]      req_pixel_x,
   input  logic [dst_pkg::PIX_W-1:0]      req_pixel_y,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_running,
   input  logic                           rsp_frame_drawn,
   input  logic [1:0]                     rsp_source,
   input  logic [dst_pkg::PIX_W-1:0]      rsp_src_x,
   input  logic [dst_pkg::PIX_W-1:0]      rsp_src_y,
   input  logic [dst_pkg::ALPHA_W-1:0]    rsp_alpha,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [dst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dst_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             outstanding,
   output int                             results_checked,
   output int                             frames_seen,
   output int                             pixels_sourced
);
   import dst_pkg::*;

   typedef struct packed {
      logic               running;
      logic               frame_drawn;
      src_type            source;
      logic [PIX_W-1:0]   src_x;
      logic [PIX_W-1:0]   src_y;
      logic [ALPHA_W-1:0] alpha;
   } pixel_result_type;

   mode_type                cfg_mode;
   dir_type                 cfg_dir;
   logic [SPEED_W-1:0]      cfg_speed;
   logic [CFG_DIM_W-1:0]    cfg_width;
   logic [CFG_DIM_W-1:0]    cfg_height;

   logic [ALPHA_W-1:0]      fade_lvl;
   logic [ALPHA_W-1:0]      shown_alpha;
   logic signed [OFS_W-1:0] ofs_x;
   logic signed [OFS_W-1:0] ofs_y;
   logic                    in_progress;

   pixel_result_type expected_results[$];

   task automatic report(string msg);
      if (mismatches < 25)
         $display("%0t checker: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   function automatic int clip_dim(logic [CFG_DIM_W-1:0] v);
      if (v == '0)
         return 1;
      if (v > MAX_DIM)
         return MAX_DIM;
      return int'(v);
   endfunction

   function automatic logic draw_frame();
      int t;
      if (!in_progress)
         return 1'b0;
      if (cfg_mode == MODE_FADE) begin
         shown_alpha = fade_lvl;
         if (fade_lvl == FADE_MAX) begin
            in_progress = 1'b0;
         end else begin
            t = int'(fade_lvl) + int'(FADE_STEP);
            fade_lvl = (t > int'(FADE_MAX)) ? FADE_MAX : ALPHA_W'(t);
         end
      end else begin
         case (cfg_dir)
            DIR_UP: begin
               t = int'(ofs_y) + int'(cfg_speed);
               ofs_y = (t > 0) ? '0 : OFS_W'(t);
            end
            DIR_DOWN: begin
               t = int'(ofs_y) - int'(cfg_speed);
               ofs_y = (t < 0) ? '0 : OFS_W'(t);
            end
            DIR_LEFT: begin
               t = int'(ofs_x) + int'(cfg_speed);
               ofs_x = (t > 0) ? '0 : OFS_W'(t);
            end
            default: begin
               t = int'(ofs_x) - int'(cfg_speed);
               ofs_x = (t < 0) ? '0 : OFS_W'(t);
            end
         endcase
         if (ofs_x == 0 && ofs_y == 0)
            in_progress = 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic pixel_result_type predict_transition(action_type act, int px, int py);
      pixel_result_type r;
      int               w, h, ox, oy, sx, sy;
      logic             hit, in_view;
      src_type          src;
      r = '0;
      w = clip_dim(cfg_width);
      h = clip_dim(cfg_height);
      hit = 1'b0;
      src = SRC_LEAVE;
      sx = 0;
      sy = 0;
      case (act)
         ACT_START: begin
            fade_lvl = '0;
            ofs_x = '0;
            ofs_y = '0;
            case (cfg_dir)
               DIR_UP:   ofs_y = OFS_W'(-h);
               DIR_DOWN: ofs_y = OFS_W'(h);
               DIR_LEFT: ofs_x = OFS_W'(-w);
               default:  ofs_x = OFS_W'(w);
            endcase
            in_progress = 1'b1;
         end
         ACT_STEP: r.frame_drawn = draw_frame();
         ACT_QUERY: begin
            ox = int'(ofs_x);
            oy = int'(ofs_y);
            if (px < w && py < h) begin
               if (cfg_mode == MODE_FADE) begin
                  r.source = SRC_BLEND;
                  r.src_x = PIX_W'(px);
                  r.src_y = PIX_W'(py);
                  r.alpha = shown_alpha;
               end else begin
                  in_view = (px + ox >= 0) && (px + ox < w) && (py + oy >= 0) && (py + oy < h);
                  if (in_view) begin
                     hit = 1'b1;
                     if (cfg_mode == MODE_SLIDE_BG) begin
                        src = SRC_BG;
                        sx = px;
                        sy = py;
                     end else begin
                        src = SRC_FG;
                        sx = px + ox;
                        sy = py + oy;
                     end
                  end else if (cfg_mode != MODE_SLIDE) begin
                     hit = 1'b1;
                     src = (cfg_mode == MODE_SLIDE_BG) ? SRC_FG : SRC_BG;
                     sx = px;
                     sy = py;
                     case (cfg_dir)
                        DIR_UP:   sy = py + h + oy;
                        DIR_DOWN: sy = py - h + oy;
                        DIR_LEFT: sx = px + w + ox;
                        default:  sx = px - w + ox;
                     endcase
                  end
                  if (hit && sx >= 0 && sx < w && sy >= 0 && sy < h) begin
                     r.source = src;
                     r.src_x = PIX_W'(sx);
                     r.src_y = PIX_W'(sy);
                  end
               end
            end
         end
         default: begin
            if (in_progress) begin
               if (cfg_mode == MODE_FADE) begin
                  fade_lvl = FADE_MAX;
               end else begin
                  ofs_x = '0;
                  ofs_y = '0;
               end
               r.frame_drawn = draw_frame();
               in_progress = 1'b0;
            end
         end
      endcase
      r.running = in_progress;
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         cfg_mode = RST_MODE;
         cfg_dir = RST_DIR;
         cfg_speed = RST_SPEED;
         cfg_width = RST_WIDTH;
         cfg_height = RST_HEIGHT;
         fade_lvl = '0;
         shown_alpha = '0;
         ofs_x = '0;
         ofs_y = '0;
         in_progress = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report("response beat with no request waiting");
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               check_field("running", rsp_running, want.running);
               check_field("frame_drawn", rsp_frame_drawn, want.frame_drawn);
               check_field("source", rsp_source, want.source);
               check_field("src_x", rsp_src_x, want.src_x);
               check_field("src_y", rsp_src_y, want.src_y);
               check_field("alpha", rsp_alpha, want.alpha);
               if (want.frame_drawn)
                  frames_seen++;
               if (want.source != SRC_LEAVE)
                  pixels_sourced++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:      cfg_mode = mode_type'(csr_wdata[1:0]);
               CSR_DIRECTION: cfg_dir = dir_type'(csr_wdata[1:0]);
               CSR_SPEED:     cfg_speed = csr_wdata[SPEED_W-1:0];
               CSR_WIDTH:     cfg_width = csr_wdata;
               CSR_HEIGHT:    cfg_height = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_results.push_back(predict_transition(action_type'(req_action),
                                       int'(req_pixel_x), int'(req_pixel_y)));
      end
      outstanding <= expected_results.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the display slide transition engine: clock, reset, request and
// register stimulus, response stalls and the verdict. Depends on dst_pkg, the block
// and dst_result_checker, which predicts and compares every response beat.
module tb;
   import dst_pkg::*;

   localparam int PHASES      = 16;
   localparam int PER_PHASE   = 100;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_action = '0;
   logic [PIX_W-1:0]      req_pixel_x = '0;
   logic [PIX_W-1:0]      req_pixel_y = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_running;
   logic                  rsp_frame_drawn;
   logic [1:0]            rsp_source;
   logic [PIX_W-1:0]      rsp_src_x;
   logic [PIX_W-1:0]      rsp_src_y;
   logic [ALPHA_W-1:0]    rsp_alpha;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches, outstanding, results_checked, frames_seen, pixels_sourced;
   int tx_pct = 0;
   int rx_pct = 0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet = 0;
   int beats_sent = 0;
   int settings_used = 0;
   int frame_cols = 64;
   int frame_rows = 32;

   always #5 clock = ~clock;

   display_slide_transition_top u_dut (.*);

   dst_result_checker u_check (
      .*,
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .results_checked(results_checked),
      .frames_seen    (frames_seen),
      .pixels_sourced (pixels_sourced)
   );

   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send(action_type act, logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      @(negedge clock);
      while ($urandom_range(99) < tx_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_pixel_x <= px;
      req_pixel_y <= py;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic cfg_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CFG_DIM_W-1:0] pick_dim();
      case ($urandom_range(9))
         0:       return '0;
         1:       return CFG_DIM_W'(1);
         2:       return CFG_DIM_W'(MAX_DIM);
         3:       return CFG_DIM_W'($urandom_range(MAX_DIM + 1, 511));
         default: return CFG_DIM_W'($urandom_range(1, 80));
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pick_coord(int n);
      if ($urandom_range(7) == 0)
         return PIX_W'($urandom_range(255));
      return PIX_W'($urandom_range(n - 1));
   endfunction

   task automatic send_query();
      send(ACT_QUERY, pick_coord(frame_cols), pick_coord(frame_rows));
   endtask

   task automatic run_sequence();
      if ($urandom_range(9) < 8) begin
         send(ACT_START, PIX_W'($urandom), PIX_W'($urandom));
         repeat ($urandom_range(1, 16)) begin
            send(ACT_STEP, PIX_W'($urandom), PIX_W'($urandom));
            repeat ($urandom_range(0, 3)) send_query();
         end
         if ($urandom_range(1))
            send(ACT_FINISH, PIX_W'($urandom), PIX_W'($urandom));
         repeat ($urandom_range(1, 3)) send_query();
      end else begin
         repeat ($urandom_range(1, 4))
            send(action_type'($urandom_range(3)), PIX_W'($urandom), PIX_W'($urandom));
      end
   endtask

   initial begin
      int                    start_count;
      logic [CFG_DIM_W-1:0]  wv, hv;
      logic [SPEED_W-1:0]    sv;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle block, then a slide at the reset settings
      send(ACT_QUERY, 8'd255, 8'd255);
      send(ACT_QUERY, 8'd0, 8'd0);
      send(ACT_STEP, 8'd0, 8'd0);
      send(ACT_FINISH, 8'd0, 8'd0);
      send(ACT_START, 8'd0, 8'd0);
      send(ACT_QUERY, 8'd0, 8'd31);
      send(ACT_STEP, 8'd255, 8'd255);
      send(ACT_QUERY, 8'd63, 8'd0);
      send(ACT_FINISH, 8'd0, 8'd0);
      send(ACT_QUERY, 8'd63, 8'd31);

      drain();
      cfg_write(CSR_MODE, CSR_DATA_W'(MODE_FADE));
      cfg_write(CSR_SPEED, '0);
      send(ACT_START, 8'd0, 8'd0);
      send(ACT_STEP, 8'd0, 8'd0);
      send(ACT_STEP, 8'd0, 8'd0);
      send(ACT_QUERY, 8'd10, 8'd5);
      send(ACT_FINISH, 8'd0, 8'd0);
      send(ACT_QUERY, 8'd63, 8'd31);

      // zero speed, width below range, height above range
      drain();
      cfg_write(CSR_MODE, CSR_DATA_W'(MODE_SHIFT));
      cfg_write(CSR_DIRECTION, CSR_DATA_W'(DIR_RIGHT));
      cfg_write(CSR_WIDTH, '0);
      cfg_write(CSR_HEIGHT, CSR_DATA_W'(511));
      send(ACT_START, 8'd0, 8'd0);
      send(ACT_STEP, 8'd0, 8'd0);
      send(ACT_QUERY, 8'd0, 8'd255);
      send(ACT_QUERY, 8'd1, 8'd0);

      // change direction, mode, size and speed mid-transition so the wrapped source leaves the frame
      drain();
      cfg_write(CSR_DIRECTION, CSR_DATA_W'(DIR_LEFT));
      cfg_write(CSR_MODE, CSR_DATA_W'(MODE_SLIDE_BG));
      cfg_write(CSR_WIDTH, CSR_DATA_W'(MAX_DIM));
      cfg_write(CSR_SPEED, CSR_DATA_W'(255));
      send(ACT_QUERY, 8'd200, 8'd7);
      send(ACT_QUERY, 8'd255, 8'd100);
      send(ACT_STEP, 8'd0, 8'd0);
      send(ACT_QUERY, 8'd128, 8'd128);
      settings_used = 4;

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         tx_pct = 0;
         rx_pct = 0;
         wv = pick_dim();
         hv = pick_dim();
         case ($urandom_range(5))
            0:       sv = '0;
            1:       sv = 8'd255;
            default: sv = SPEED_W'($urandom_range(1, 60));
         endcase
         cfg_write(CSR_MODE, {7'($urandom), 2'(ph % 4)});
         cfg_write(CSR_DIRECTION, {7'($urandom), 2'((ph / 4) % 4)});
         cfg_write(CSR_SPEED, {1'($urandom), sv});
         cfg_write(CSR_WIDTH, wv);
         cfg_write(CSR_HEIGHT, hv);
         cfg_write(CSR_IDX_W'($urandom_range(5, 7)), CSR_DATA_W'($urandom));
         frame_cols = (wv == 0) ? 1 : ((wv > MAX_DIM) ? MAX_DIM : int'(wv));
         frame_rows = (hv == 0) ? 1 : ((hv > MAX_DIM) ? MAX_DIM : int'(hv));
         settings_used++;
         case ((ph + ph / 4) % 4)
            0: ;
            1: tx_pct = 64;
            2: rx_pct = 64;
            default: begin
               tx_pct = 33;
               rx_pct = 33;
            end
         endcase
         // back up the response side while requests keep coming
         if (ph % 8 == 0)
            hold_asked++;
         start_count = beats_sent;
         while (beats_sent - start_count < PER_PHASE)
            run_sequence();
      end

      drain();
      repeat (10) @(posedge clock);
      $display("summary: %0d request beats over %0d register settings, %0d responses checked",
               beats_sent, settings_used, results_checked);
      $display("summary: %0d frames drawn, %0d pixel queries mapped to a buffer",
               frames_seen, pixels_sourced);
      if (mismatches == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> sim.f
src/dst_pkg.sv
src/dst_csr.sv
src/dst_state.sv
src/dst_query.sv
src/display_slide_transition_top.sv
src/dst_check.sv
tb/dst_result_checker.sv
tb/tb.sv
